// File: hw/rtl/cts_pkg.sv
// Package for the token scanner: result kind codes, scan modes, character
// classes and keyword tables. No dependencies.
`timescale 1ns / 1ps

package cts_pkg;

	localparam int LEN_W      = 16;
	localparam int KIND_W     = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int NUM_KW     = 3;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// result kinds
	localparam logic [KIND_W-1:0] K_CHAR      = 4'd0;
	localparam logic [KIND_W-1:0] K_LBRACE    = 4'd1;
	localparam logic [KIND_W-1:0] K_RBRACE    = 4'd2;
	localparam logic [KIND_W-1:0] K_LPAREN    = 4'd3;
	localparam logic [KIND_W-1:0] K_RPAREN    = 4'd4;
	localparam logic [KIND_W-1:0] K_SEMI      = 4'd5;
	localparam logic [KIND_W-1:0] K_ASSIGN    = 4'd6;
	localparam logic [KIND_W-1:0] K_NUMBER    = 4'd7;
	localparam logic [KIND_W-1:0] K_STRING    = 4'd8;
	localparam logic [KIND_W-1:0] K_IDENT     = 4'd9;
	localparam logic [KIND_W-1:0] K_KW_MAIN   = 4'd10;
	localparam logic [KIND_W-1:0] K_KW_RETURN = 4'd11;
	localparam logic [KIND_W-1:0] K_KW_INT    = 4'd12;
	localparam logic [KIND_W-1:0] K_UNTERM    = 4'd13;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_NUM   = 2'd1,
		MODE_STR   = 2'd2,
		MODE_IDENT = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        char_out;
		logic [LEN_W-1:0]  token_length;
		logic              last;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return is_alpha(c) || (c == "_") || (c == "-");
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_ident_start(c) || is_digit(c);
	endfunction

	// punctuator kind, K_CHAR when the byte is not one
	function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			";":     k = K_SEMI;
			"=":     k = K_ASSIGN;
			default: k = K_CHAR;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] l;
		case (k)
			0:       l = 3'd4;
			1:       l = 3'd6;
			default: l = 3'd3;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			0: begin
				case (pos)
					3'd0:    c = "m";
					3'd1:    c = "a";
					3'd2:    c = "i";
					3'd3:    c = "n";
					default: c = 8'h00;
				endcase
			end
			1: begin
				case (pos)
					3'd0:    c = "r";
					3'd1:    c = "e";
					3'd2:    c = "t";
					3'd3:    c = "u";
					3'd4:    c = "r";
					3'd5:    c = "n";
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0:    c = "i";
					3'd1:    c = "n";
					3'd2:    c = "t";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	// keywords that still agree with byte c placed at position pos
	function automatic logic [NUM_KW-1:0] kw_hit(input logic [LEN_W-1:0] pos,
			input logic [7:0] c);
		logic [NUM_KW-1:0] h;
		for (int k = 0; k < NUM_KW; k++) begin
			h[k] = (pos < LEN_W'(kw_len(k))) && (kw_char(k, pos[2:0]) == c);
		end
		return h;
	endfunction

endpackage

// File: hw/rtl/c_subset_token_scanner.sv
// Top level of the token scanner: input stage, single-pass scan logic and
// a four-word result queue. Depends on cts_pkg.
`timescale 1ns / 1ps

// Byte-serial scanner for a small C subset. One source byte (or an end mark
// on s_tlast) is taken per cycle; each gives zero, one or two result words.
// The scan state is updated in one pass as a byte leaves the input stage, so
// a byte is taken every cycle while the four-word result queue has room for
// two more words; a byte that yields two words writes both into the queue
// together, and results are registered in the queue after the input stage.
module c_subset_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // is_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] kind, [11:4] char_out, [27:12] token_length
	output logic        m_tlast    // last
);

	logic                        s1_valid_q;
	logic [7:0]                  ch_s1;
	logic                        end_s1;

	cts_pkg::scan_mode_t         mode_q, mode_d;
	logic [cts_pkg::LEN_W-1:0]   run_len_q, run_len_d;
	logic [cts_pkg::NUM_KW-1:0]  km_q, km_d;

	cts_pkg::result_t            fifo_q [cts_pkg::FIFO_DEPTH];
	logic [cts_pkg::FIFO_AW-1:0] wp_q, rp_q;
	logic [cts_pkg::FIFO_AW:0]   count_q;

	cts_pkg::result_t            r0, r1;
	logic [1:0]                  n_res;
	logic                        fire, pop;

	assign fire     = s1_valid_q && (count_q <= (cts_pkg::FIFO_AW+1)'(cts_pkg::FIFO_DEPTH - 2));
	assign s_tready = !s1_valid_q || fire;
	assign pop      = m_tvalid && m_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	// scan pass
	always_comb begin
		logic [cts_pkg::KIND_W-1:0] end_kind, pk;
		logic [cts_pkg::LEN_W-1:0]  bumped;
		logic                       st_emit;
		cts_pkg::scan_mode_t        st_mode;
		logic [cts_pkg::NUM_KW-1:0] st_km;
		logic                       st_tok;

		bumped = (run_len_q == cts_pkg::LEN_MAX) ? run_len_q
			: run_len_q + cts_pkg::LEN_W'(1);

		// kind of the token that ends now (number, string, identifier or keyword)
		end_kind = cts_pkg::K_IDENT;
		for (int k = 0; k < cts_pkg::NUM_KW; k++) begin
			if (km_q[k] && (run_len_q == cts_pkg::LEN_W'(cts_pkg::kw_len(k)))) begin
				end_kind = cts_pkg::K_KW_MAIN + cts_pkg::KIND_W'(k);
			end
		end
		if (mode_q == cts_pkg::MODE_NUM) begin
			end_kind = cts_pkg::K_NUMBER;
		end else if (mode_q == cts_pkg::MODE_STR) begin
			end_kind = end_s1 ? cts_pkg::K_UNTERM : cts_pkg::K_STRING;
		end

		// treat the byte as if idle
		pk      = cts_pkg::punct_kind(ch_s1);
		st_tok  = 1'b1;
		st_mode = cts_pkg::MODE_IDLE;
		st_km   = '0;
		if (cts_pkg::is_digit(ch_s1)) begin
			st_mode = cts_pkg::MODE_NUM;
		end else if (ch_s1 == "\"") begin
			st_mode = cts_pkg::MODE_STR;
		end else if (cts_pkg::is_ident_start(ch_s1)) begin
			st_mode = cts_pkg::MODE_IDENT;
			st_km   = cts_pkg::kw_hit('0, ch_s1);
		end else begin
			st_tok = 1'b0;
		end
		st_emit = st_tok || (pk != cts_pkg::K_CHAR);

		r0 = '{kind: cts_pkg::K_CHAR, char_out: ch_s1, token_length: '0, last: 1'b0};
		r1 = '{kind: cts_pkg::K_CHAR, char_out: ch_s1, token_length: '0, last: 1'b1};
		if (!st_tok) begin
			r1.kind = pk;
		end
		n_res     = 2'd0;
		mode_d    = mode_q;
		run_len_d = run_len_q;
		km_d      = km_q;

		if (end_s1) begin
			if (mode_q != cts_pkg::MODE_IDLE) begin
				r0        = '{kind: end_kind, char_out: '0, token_length: run_len_q, last: 1'b1};
				n_res     = 2'd1;
				mode_d    = cts_pkg::MODE_IDLE;
				run_len_d = '0;
				km_d      = '0;
			end
		end else if (mode_q == cts_pkg::MODE_STR) begin
			if (ch_s1 == "\"") begin
				r1        = '{kind: cts_pkg::K_STRING, char_out: '0, token_length: bumped,
					last: 1'b1};
				n_res     = 2'd2;
				mode_d    = cts_pkg::MODE_IDLE;
				run_len_d = '0;
				km_d      = '0;
			end else begin
				r0.last   = 1'b1;
				n_res     = 2'd1;
				run_len_d = bumped;
			end
		end else if ((mode_q == cts_pkg::MODE_NUM
				&& (cts_pkg::is_digit(ch_s1) || ch_s1 == "."))
				|| (mode_q == cts_pkg::MODE_IDENT && cts_pkg::is_ident_char(ch_s1))) begin
			// token continues
			r0.last   = 1'b1;
			n_res     = 2'd1;
			run_len_d = bumped;
			if (mode_q == cts_pkg::MODE_IDENT) begin
				km_d = km_q & cts_pkg::kw_hit(run_len_q, ch_s1);
			end
		end else if (mode_q != cts_pkg::MODE_IDLE) begin
			// token ended by this byte, which then starts afresh
			r0        = '{kind: end_kind, char_out: '0, token_length: run_len_q,
				last: !st_emit};
			n_res     = st_emit ? 2'd2 : 2'd1;
			mode_d    = st_mode;
			run_len_d = st_tok ? cts_pkg::LEN_W'(1) : '0;
			km_d      = st_km;
		end else begin
			if (st_emit) begin
				r0      = r1;
				n_res   = 2'd1;
			end
			mode_d    = st_mode;
			run_len_d = st_tok ? cts_pkg::LEN_W'(1) : '0;
			km_d      = st_km;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= cts_pkg::MODE_IDLE;
			run_len_q <= '0;
			km_q      <= '0;
		end else if (fire) begin
			mode_q    <= mode_d;
			run_len_q <= run_len_d;
			km_q      <= km_d;
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + (fire ? cts_pkg::FIFO_AW'(n_res) : '0);
			rp_q    <= rp_q + cts_pkg::FIFO_AW'(pop);
			count_q <= count_q + (fire ? (cts_pkg::FIFO_AW+1)'(n_res) : '0)
				- (cts_pkg::FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0) begin
			fifo_q[wp_q] <= r0;
		end
		if (fire && n_res == 2'd2) begin
			fifo_q[wp_q + cts_pkg::FIFO_AW'(1)] <= r1;
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {4'b0, fifo_q[rp_q].token_length, fifo_q[rp_q].char_out,
		fifo_q[rp_q].kind};
	assign m_tlast  = fifo_q[rp_q].last;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (cts_pkg::FIFO_AW+1)'(cts_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_q && count_q > (cts_pkg::FIFO_AW+1)'(cts_pkg::FIFO_DEPTH - 2))
		else $error("input stalled without cause");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_s1 |=> mode_q == cts_pkg::MODE_IDLE)
		else $error("end mark did not close the token");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == cts_pkg::MODE_IDLE |-> run_len_q == '0 && km_q == '0)
		else $error("idle with stale token state");

	a_num_no_kw: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == cts_pkg::MODE_NUM |-> km_q == '0)
		else $error("keyword match live inside a number");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking bench for the token scanner: directed table, then random source
// text, each word checked against a local scan model or a value typed in.
// Depends on cts_pkg and c_subset_token_scanner.
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT     = 600000;
	localparam int PHASE_ITEMS [3] = '{550, 350, 400};

	// how a directed row is checked: by the scan model, by the value typed in, or as yielding no result
	typedef enum logic [1:0] {T_PRED, T_NONE, T_ONE} chk_t;

	typedef struct packed {
		logic [7:0]                 ch;
		logic                       eoi;
		chk_t                       chk;
		logic [cts_pkg::KIND_W-1:0] kind;
		logic [7:0]                 chr;
		logic [cts_pkg::LEN_W-1:0]  len;
	} row_t;

	row_t dir_rows [26] = '{
		'{8'h00, 1'b1, T_NONE, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"{",   1'b0, T_ONE,  cts_pkg::K_LBRACE, "{",   16'd0},
		'{"}",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"(",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{")",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{";",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"=",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'h00, 1'b0, T_NONE, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'hFF, 1'b0, T_NONE, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'h1B, 1'b0, T_NONE, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"0",   1'b0, T_ONE,  cts_pkg::K_CHAR,   "0",   16'd0},
		'{".",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"9",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{")",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"\"",  1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'h09, 1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'hFF, 1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"\"",  1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"i",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"n",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{"t",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'h20, 1'b0, T_ONE,  cts_pkg::K_KW_INT, 8'h00, 16'd3},
		'{"_",   1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'hFF, 1'b1, T_ONE,  cts_pkg::K_IDENT,  8'h00, 16'd1},
		'{"\"",  1'b0, T_PRED, cts_pkg::K_CHAR,   8'h00, 16'd0},
		'{8'h00, 1'b1, T_ONE,  cts_pkg::K_UNTERM, 8'h00, 16'd1}
	};

	logic [7:0] blank_bytes [6] = '{8'h08, 8'h0C, 8'h0A, 8'h20, 8'h09, 8'h1B};
	string      kw_text [3] = '{"main", "return", "int"};
	string      punct_text = "{}();=";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	bit run_en = 1'b0;
	bit quiet = 1'b0;
	bit in_busy = 1'b0;
	int cycles = 0;
	int mismatches = 0;
	int n_in = 0;
	int n_out = 0;
	int n_queued = 0;
	logic [15:0] kinds_seen = '0;

	// scan model state
	cts_pkg::scan_mode_t       lex_mode = cts_pkg::MODE_IDLE;
	logic [cts_pkg::LEN_W-1:0] tok_len = '0;
	logic [2:0]                kw_alive = '0;

	cts_pkg::result_t step_out [$];
	cts_pkg::result_t token_q [$];
	row_t             pend [$];

	c_subset_token_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic bit digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit word_char(logic [7:0] c);
		return letter_c(c) || digit_c(c) || c == "_" || c == "-";
	endfunction

	function automatic bit blank_c(logic [7:0] c);
		bit hit;
		hit = 1'b0;
		foreach (blank_bytes[i])
			if (blank_bytes[i] == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic [cts_pkg::KIND_W-1:0] punct_code(logic [7:0] c);
		logic [cts_pkg::KIND_W-1:0] k;
		case (c)
			"{":     k = cts_pkg::K_LBRACE;
			"}":     k = cts_pkg::K_RBRACE;
			"(":     k = cts_pkg::K_LPAREN;
			")":     k = cts_pkg::K_RPAREN;
			";":     k = cts_pkg::K_SEMI;
			"=":     k = cts_pkg::K_ASSIGN;
			default: k = cts_pkg::K_CHAR;
		endcase
		return k;
	endfunction

	function automatic void emit(logic [cts_pkg::KIND_W-1:0] kind, logic [7:0] c,
			logic [cts_pkg::LEN_W-1:0] len);
		step_out.push_back('{kind, c, len, 1'b0});
	endfunction

	// drop keywords that no longer agree with byte c at the current position
	function automatic void trim_kw(logic [7:0] c);
		for (int k = 0; k < 3; k++)
			if (tok_len >= kw_text[k].len() || kw_text[k][tok_len] != c)
				kw_alive[k] = 1'b0;
	endfunction

	function automatic void close_token(bit at_end);
		logic [cts_pkg::KIND_W-1:0] kind;
		kind = cts_pkg::K_IDENT;
		case (lex_mode)
			cts_pkg::MODE_NUM: kind = cts_pkg::K_NUMBER;
			cts_pkg::MODE_STR: kind = at_end ? cts_pkg::K_UNTERM : cts_pkg::K_STRING;
			default: begin
				for (int k = 0; k < 3; k++)
					if (kw_alive[k] && tok_len == kw_text[k].len())
						kind = cts_pkg::K_KW_MAIN + cts_pkg::KIND_W'(k);
			end
		endcase
		emit(kind, 8'h00, tok_len);
		lex_mode = cts_pkg::MODE_IDLE;
		tok_len = '0;
		kw_alive = '0;
	endfunction

	function automatic void open_token(logic [7:0] c);
		logic [cts_pkg::KIND_W-1:0] p;
		p = punct_code(c);
		if (blank_c(c))
			return;
		if (p != cts_pkg::K_CHAR) begin
			emit(p, c, '0);
			return;
		end
		if (digit_c(c)) begin
			lex_mode = cts_pkg::MODE_NUM;
		end else if (c == "\"") begin
			lex_mode = cts_pkg::MODE_STR;
		end else if (letter_c(c) || c == "_" || c == "-") begin
			lex_mode = cts_pkg::MODE_IDENT;
			kw_alive = 3'b111;
			trim_kw(c);
		end else begin
			return;
		end
		tok_len = 1;
		emit(cts_pkg::K_CHAR, c, '0);
	endfunction

	// one source word through the scan model; results land in step_out
	function automatic void lex_step(logic [7:0] c, logic eoi);
		step_out.delete();
		if (eoi) begin
			if (lex_mode != cts_pkg::MODE_IDLE)
				close_token(1'b1);
		end else begin
			case (lex_mode)
				cts_pkg::MODE_STR: begin
					if (tok_len != cts_pkg::LEN_MAX)
						tok_len++;
					emit(cts_pkg::K_CHAR, c, '0);
					if (c == "\"")
						close_token(1'b0);
				end
				cts_pkg::MODE_NUM: begin
					if (digit_c(c) || c == ".") begin
						if (tok_len != cts_pkg::LEN_MAX)
							tok_len++;
						emit(cts_pkg::K_CHAR, c, '0);
					end else begin
						close_token(1'b0);
						open_token(c);
					end
				end
				cts_pkg::MODE_IDENT: begin
					if (word_char(c)) begin
						trim_kw(c);
						if (tok_len != cts_pkg::LEN_MAX)
							tok_len++;
						emit(cts_pkg::K_CHAR, c, '0);
					end else begin
						close_token(1'b0);
						open_token(c);
					end
				end
				default: open_token(c);
			endcase
		end
		if (step_out.size() > 0)
			step_out[step_out.size()-1].last = 1'b1;
	endfunction

	task automatic put(logic [7:0] c, logic eoi);
		pend.push_back('{c, eoi, T_PRED, cts_pkg::K_CHAR, 8'h00, 16'd0});
		n_queued++;
	endtask

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(63);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r < 62)
			return 8'("0" + r - 52);
		return (r == 62) ? 8'("_") : 8'("-");
	endfunction

	// one random token, mostly well formed, with a separator now and then
	task automatic put_token();
		int sel, n, k, r;
		logic [7:0] c;
		sel = $urandom_range(99);
		if (sel < 12) begin
			// keyword, sometimes cut short or overrun
			k = $urandom_range(2);
			r = $urandom_range(5);
			n = kw_text[k].len() - ((r == 0) ? 1 : 0);
			for (int i = 0; i < n; i++)
				put(kw_text[k][i], 1'b0);
			if (r == 1)
				put(rand_word_char(), 1'b0);
		end else if (sel < 30) begin
			if ($urandom_range(2) == 0) begin
				k = $urandom_range(2);
				n = $urandom_range(1, kw_text[k].len());
				for (int i = 0; i < n; i++)
					put(kw_text[k][i], 1'b0);
			end else begin
				do
					c = rand_word_char();
				while (digit_c(c));
				put(c, 1'b0);
			end
			repeat ($urandom_range(6))
				put(rand_word_char(), 1'b0);
		end else if (sel < 45) begin
			put(8'("0" + $urandom_range(9)), 1'b0);
			repeat ($urandom_range(5))
				put(($urandom_range(3) == 0) ? 8'(".") : 8'("0" + $urandom_range(9)), 1'b0);
		end else if (sel < 57) begin
			put("\"", 1'b0);
			repeat ($urandom_range(8)) begin
				do
					c = 8'($urandom_range(255));
				while (c == "\"");
				put(c, 1'b0);
			end
			if ($urandom_range(6) != 0)
				put("\"", 1'b0);
		end else if (sel < 72) begin
			put(punct_text[$urandom_range(5)], 1'b0);
		end else if (sel < 82) begin
			put(blank_bytes[$urandom_range(5)], 1'b0);
		end else if (sel < 88) begin
			r = $urandom_range(3);
			case (r)
				0:       put(".", 1'b0);
				1:       put(8'h0D, 1'b0);
				2:       put(8'($urandom_range(128, 255)), 1'b0);
				default: put(8'($urandom_range(255)), 1'b0);
			endcase
		end else if (sel < 94) begin
			put(8'($urandom_range(255)), 1'b1);
		end else begin
			put(8'($urandom_range(255)), 1'b0);
		end
		if ($urandom_range(1) == 0)
			put(blank_bytes[$urandom_range(5)], 1'b0);
	endtask

	task automatic flag(string why, cts_pkg::result_t want, cts_pkg::result_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: want kind %0d char %h len %0d last %b, %s %0d %h %0d %b",
				$time, why, want.kind, want.char_out, want.token_length, want.last,
				"got kind/char/len/last", seen.kind, seen.char_out,
				seen.token_length, seen.last);
	endtask

	task automatic drain();
		while (pend.size() != 0 || token_q.size() != 0)
			@(posedge clk);
	endtask

	// drive on the falling edge; a presented word is held until taken
	always @(negedge clk) begin
		if (!run_en) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 13);
			if (!in_busy) begin
				if (pend.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pend[0].ch;
					s_tlast  <= pend[0].eoi;
					in_busy = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sample on the rising edge: results first, then the word taken this edge
	always @(posedge clk) begin
		cts_pkg::result_t seen, want;
		row_t row;
		if (m_tvalid && m_tready) begin
			seen = '{m_tdata[3:0], m_tdata[11:4], m_tdata[27:12], m_tlast};
			n_out++;
			kinds_seen[seen.kind] = 1'b1;
			if (token_q.size() == 0) begin
				flag("unexpected result", '0, seen);
			end else begin
				want = token_q.pop_front();
				if (seen != want || m_tdata[31:28] != 4'h0)
					flag("result mismatch", want, seen);
			end
		end
		if (s_tvalid && s_tready) begin
			row = pend.pop_front();
			in_busy = 1'b0;
			n_in++;
			lex_step(row.ch, row.eoi);
			case (row.chk)
				T_PRED:  foreach (step_out[i]) token_q.push_back(step_out[i]);
				T_ONE:   token_q.push_back('{row.kind, row.chr, row.len, 1'b1});
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				token_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk) run_en = 1'b1;

		foreach (dir_rows[i])
			pend.push_back(dir_rows[i]);
		drain();

		// middle phase runs with both sides streaming flat out
		for (int ph = 0; ph < 3; ph++) begin
			quiet = (ph == 1);
			n_queued = 0;
			while (n_queued < PHASE_ITEMS[ph])
				put_token();
			drain();
		end
		quiet = 1'b0;
		repeat (8) @(posedge clk);

		$display("%0d source words in, %0d result words checked, %0d mismatches",
			n_in, n_out, mismatches);
		$display("directed table then random text, stalled and flat out; kinds seen: %b",
			kinds_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
